[rtl/core/qvr_pkg.sv]
// package: widths, payload types and rounding helpers for the quaternion rotation pipeline
package qvr_pkg;

    localparam int QUAT_WIDTH = 16;
    localparam int VEC_WIDTH  = 24;
    localparam int MAT_FRAC   = 18;
    localparam int FRAC_SHIFT = 2 * (QUAT_WIDTH - 1) - MAT_FRAC;

    localparam int QX_W   = QUAT_WIDTH + 1;
    localparam int PROD_W = 2 * QUAT_WIDTH;
    localparam int SUM_W  = 2 * QUAT_WIDTH + 2;
    localparam int MAT_W  = SUM_W - FRAC_SHIFT;
    localparam int MP_W   = MAT_W + VEC_WIDTH;
    localparam int ACC_W  = MP_W + 2;
    localparam int RND_W  = ACC_W + 1 - MAT_FRAC;
    localparam int NUM_ELEM = 9;

    localparam logic [SUM_W:0] MAT_HALF = (SUM_W + 1)'(1) << (FRAC_SHIFT - 1);
    localparam logic [ACC_W:0] ACC_HALF = (ACC_W + 1)'(1) << (MAT_FRAC - 1);

    localparam logic signed [VEC_WIDTH-1:0] VEC_MAX = {1'b0, {(VEC_WIDTH - 1){1'b1}}};
    localparam logic signed [VEC_WIDTH-1:0] VEC_MIN = {1'b1, {(VEC_WIDTH - 1){1'b0}}};

    typedef logic signed [PROD_W-1:0] prod_elem_t;
    typedef logic signed [MAT_W-1:0]  mat_elem_t;
    typedef logic signed [MP_W-1:0]   mp_elem_t;

    typedef struct packed {
        logic signed [VEC_WIDTH-1:0] x;
        logic signed [VEC_WIDTH-1:0] y;
        logic signed [VEC_WIDTH-1:0] z;
    } vec_t;

    typedef struct packed {
        prod_elem_t ww;
        prod_elem_t wx;
        prod_elem_t wy;
        prod_elem_t wz;
        prod_elem_t xx;
        prod_elem_t xy;
        prod_elem_t xz;
        prod_elem_t yy;
        prod_elem_t yz;
        prod_elem_t zz;
    } prod_t;

    typedef mat_elem_t [NUM_ELEM-1:0] mat_t;
    typedef mp_elem_t  [NUM_ELEM-1:0] mp_t;

    typedef struct packed {
        logic                        sat;
        logic signed [VEC_WIDTH-1:0] val;
    } sat_res_t;

    // round to nearest, ties up, from 2(q-1) to MAT_FRAC fractional bits
    function automatic mat_elem_t round_elem(input logic signed [SUM_W-1:0] s);
        logic [SUM_W:0] t;
        begin
            t = (SUM_W + 1)'(s) + MAT_HALF;
            return t[FRAC_SHIFT + MAT_W - 1:FRAC_SHIFT];
        end
    endfunction

    // round to integer, ties up, then clamp to the vector range
    function automatic sat_res_t round_sat(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W:0]           t;
        logic signed [RND_W-1:0]  r;
        sat_res_t                 res;
        begin
            t = (ACC_W + 1)'(acc) + ACC_HALF;
            r = t[ACC_W:MAT_FRAC];
            if ((&r[RND_W-1:VEC_WIDTH-1]) || !(|r[RND_W-1:VEC_WIDTH-1])) begin
                res.sat = 1'b0;
                res.val = r[VEC_WIDTH-1:0];
            end else if (r[RND_W-1]) begin
                res.sat = 1'b1;
                res.val = VEC_MIN;
            end else begin
                res.sat = 1'b1;
                res.val = VEC_MAX;
            end
            return res;
        end
    endfunction

endpackage

[rtl/core/qvr_prod.sv]
// stage one: optional conjugation and the ten pairwise quaternion products
module qvr_prod (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 in_cmd,
    input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] in_quat_w,
    input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] in_quat_x,
    input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] in_quat_y,
    input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] in_quat_z,
    input  qvr_pkg::vec_t                        in_vec,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output qvr_pkg::prod_t                       out_prod,
    output qvr_pkg::vec_t                        out_vec
);

    logic signed [qvr_pkg::QX_W-1:0] w_e;
    logic signed [qvr_pkg::QX_W-1:0] x_e;
    logic signed [qvr_pkg::QX_W-1:0] y_e;
    logic signed [qvr_pkg::QX_W-1:0] z_e;
    logic                            load;
    logic                            vld_reg;
    logic                            vld_next;
    qvr_pkg::prod_t                  prod_reg;
    qvr_pkg::prod_t                  prod_next;
    qvr_pkg::vec_t                   vec_reg;

    assign in_ready = !vld_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        w_e = qvr_pkg::QX_W'(in_quat_w);
        x_e = in_cmd ? -qvr_pkg::QX_W'(in_quat_x) : qvr_pkg::QX_W'(in_quat_x);
        y_e = in_cmd ? -qvr_pkg::QX_W'(in_quat_y) : qvr_pkg::QX_W'(in_quat_y);
        z_e = in_cmd ? -qvr_pkg::QX_W'(in_quat_z) : qvr_pkg::QX_W'(in_quat_z);
        prod_next.ww = qvr_pkg::PROD_W'(w_e) * qvr_pkg::PROD_W'(w_e);
        prod_next.wx = qvr_pkg::PROD_W'(w_e) * qvr_pkg::PROD_W'(x_e);
        prod_next.wy = qvr_pkg::PROD_W'(w_e) * qvr_pkg::PROD_W'(y_e);
        prod_next.wz = qvr_pkg::PROD_W'(w_e) * qvr_pkg::PROD_W'(z_e);
        prod_next.xx = qvr_pkg::PROD_W'(x_e) * qvr_pkg::PROD_W'(x_e);
        prod_next.xy = qvr_pkg::PROD_W'(x_e) * qvr_pkg::PROD_W'(y_e);
        prod_next.xz = qvr_pkg::PROD_W'(x_e) * qvr_pkg::PROD_W'(z_e);
        prod_next.yy = qvr_pkg::PROD_W'(y_e) * qvr_pkg::PROD_W'(y_e);
        prod_next.yz = qvr_pkg::PROD_W'(y_e) * qvr_pkg::PROD_W'(z_e);
        prod_next.zz = qvr_pkg::PROD_W'(z_e) * qvr_pkg::PROD_W'(z_e);
        vld_next     = in_ready ? in_valid : vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        if (load) begin
            prod_reg <= prod_next;
            vec_reg  <= in_vec;
        end
    end

    assign out_valid = vld_reg;
    assign out_prod  = prod_reg;
    assign out_vec   = vec_reg;

endmodule

[rtl/core/qvr_dcm.sv]
// stage two: direction cosine matrix from the quaternion products, rounded per element
module qvr_dcm (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  qvr_pkg::prod_t in_prod,
    input  qvr_pkg::vec_t  in_vec,
    output logic           out_valid,
    input  logic           out_ready,
    output qvr_pkg::mat_t  out_mat,
    output qvr_pkg::vec_t  out_vec
);

    logic signed [qvr_pkg::SUM_W-1:0] ww;
    logic signed [qvr_pkg::SUM_W-1:0] wx;
    logic signed [qvr_pkg::SUM_W-1:0] wy;
    logic signed [qvr_pkg::SUM_W-1:0] wz;
    logic signed [qvr_pkg::SUM_W-1:0] xx;
    logic signed [qvr_pkg::SUM_W-1:0] xy;
    logic signed [qvr_pkg::SUM_W-1:0] xz;
    logic signed [qvr_pkg::SUM_W-1:0] yy;
    logic signed [qvr_pkg::SUM_W-1:0] yz;
    logic signed [qvr_pkg::SUM_W-1:0] zz;
    logic                             load;
    logic                             vld_reg;
    logic                             vld_next;
    qvr_pkg::mat_t                    mat_reg;
    qvr_pkg::mat_t                    mat_next;
    qvr_pkg::vec_t                    vec_reg;

    assign in_ready = !vld_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        ww = qvr_pkg::SUM_W'(in_prod.ww);
        wx = qvr_pkg::SUM_W'(in_prod.wx);
        wy = qvr_pkg::SUM_W'(in_prod.wy);
        wz = qvr_pkg::SUM_W'(in_prod.wz);
        xx = qvr_pkg::SUM_W'(in_prod.xx);
        xy = qvr_pkg::SUM_W'(in_prod.xy);
        xz = qvr_pkg::SUM_W'(in_prod.xz);
        yy = qvr_pkg::SUM_W'(in_prod.yy);
        yz = qvr_pkg::SUM_W'(in_prod.yz);
        zz = qvr_pkg::SUM_W'(in_prod.zz);
        mat_next[0] = qvr_pkg::round_elem(ww + xx - yy - zz);
        mat_next[1] = qvr_pkg::round_elem((xy + wz) <<< 1);
        mat_next[2] = qvr_pkg::round_elem((xz - wy) <<< 1);
        mat_next[3] = qvr_pkg::round_elem((xy - wz) <<< 1);
        mat_next[4] = qvr_pkg::round_elem(ww - xx + yy - zz);
        mat_next[5] = qvr_pkg::round_elem((yz + wx) <<< 1);
        mat_next[6] = qvr_pkg::round_elem((xz + wy) <<< 1);
        mat_next[7] = qvr_pkg::round_elem((yz - wx) <<< 1);
        mat_next[8] = qvr_pkg::round_elem(ww - xx - yy + zz);
        vld_next    = in_ready ? in_valid : vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        if (load) begin
            mat_reg <= mat_next;
            vec_reg <= in_vec;
        end
    end

    assign out_valid = vld_reg;
    assign out_mat   = mat_reg;
    assign out_vec   = vec_reg;

endmodule

[rtl/core/qvr_mvm.sv]
// stages three and four: matrix times vector, rounding and saturation
module qvr_mvm (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  qvr_pkg::mat_t in_mat,
    input  qvr_pkg::vec_t in_vec,
    output logic          out_valid,
    input  logic          out_ready,
    output qvr_pkg::vec_t out_rot,
    output logic          out_sat
);

    logic signed [qvr_pkg::VEC_WIDTH-1:0] v_sel [3];
    logic                                 rdy_a;
    logic                                 rdy_b;
    logic                                 load_a;
    logic                                 load_b;
    logic                                 vld_a_reg;
    logic                                 vld_a_next;
    logic                                 vld_b_reg;
    logic                                 vld_b_next;
    qvr_pkg::mp_t                         prod_a_reg;
    qvr_pkg::mp_t                         prod_a_next;
    logic signed [qvr_pkg::ACC_W-1:0]     acc [3];
    qvr_pkg::sat_res_t                    res [3];
    qvr_pkg::vec_t                        rot_reg;
    qvr_pkg::vec_t                        rot_next;
    logic                                 sat_reg;
    logic                                 sat_next;

    assign rdy_b    = !vld_b_reg || out_ready;
    assign rdy_a    = !vld_a_reg || rdy_b;
    assign in_ready = rdy_a;
    assign load_a   = in_valid && rdy_a;
    assign load_b   = vld_a_reg && rdy_b;

    always_comb begin
        v_sel[0] = in_vec.x;
        v_sel[1] = in_vec.y;
        v_sel[2] = in_vec.z;
        for (int k = 0; k < qvr_pkg::NUM_ELEM; k++) begin
            prod_a_next[k] = qvr_pkg::MP_W'($signed(in_mat[k]))
                           * qvr_pkg::MP_W'(v_sel[k % 3]);
        end
        vld_a_next = rdy_a ? in_valid : vld_a_reg;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = qvr_pkg::ACC_W'($signed(prod_a_reg[3 * i]))
                   + qvr_pkg::ACC_W'($signed(prod_a_reg[3 * i + 1]))
                   + qvr_pkg::ACC_W'($signed(prod_a_reg[3 * i + 2]));
            res[i] = qvr_pkg::round_sat(acc[i]);
        end
        rot_next.x = res[0].val;
        rot_next.y = res[1].val;
        rot_next.z = res[2].val;
        sat_next   = res[0].sat || res[1].sat || res[2].sat;
        vld_b_next = rdy_b ? vld_a_reg : vld_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end else begin
            vld_a_reg <= vld_a_next;
            vld_b_reg <= vld_b_next;
        end
        if (load_a) begin
            prod_a_reg <= prod_a_next;
        end
        if (load_b) begin
            rot_reg <= rot_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = vld_b_reg;
    assign out_rot   = rot_reg;
    assign out_sat   = sat_reg;

`ifndef SYNTHESIS
    a_sat_at_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_sat |->
            out_rot.x == qvr_pkg::VEC_MAX || out_rot.x == qvr_pkg::VEC_MIN ||
            out_rot.y == qvr_pkg::VEC_MAX || out_rot.y == qvr_pkg::VEC_MIN ||
            out_rot.z == qvr_pkg::VEC_MAX || out_rot.z == qvr_pkg::VEC_MIN)
        else $error("sat flag without a clamped component");
    a_prod_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_a_reg && !rdy_b |=> vld_a_reg && $stable(prod_a_reg))
        else $error("product stage changed while stalled");
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> vld_a_reg)
        else $error("accepted word lost at product stage");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !vld_a_reg && !vld_b_reg)
        else $error("pipeline not empty after reset");
`endif

endmodule

[rtl/core/quaternion_vector_rotation_unit.sv]
// top level: quaternion vector rotation pipeline
//
// s_ channel: one word per item, a quaternion in Q1.15 (s_quat_w/x/y/z), a signed
// 24-bit vector (s_vec_x/y/z) and s_cmd (0 rotate, 1 rotate by the conjugate).
// m_ channel: the rotated vector m_rot_x/y/z, rounded to nearest and clamped to
// the 24-bit range, with m_sat_flag set when any component was clamped.
// each word passes through the product, matrix, multiply and round/saturate
// register stages before m_valid rises.
// throughput: one word per cycle while m_ready is high; every stage holds one
// word and passes it on when the next stage is empty or moving.
// when the receiver stalls, words pile up in the four stages and s_ready falls
// only once all of them are full; nothing is dropped or repeated.
// reset (aresetn low, synchronous) empties the pipeline; m_valid is low after it.
// a non-unit quaternion scales the result by its squared norm.
module quaternion_vector_rotation_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_cmd,
    input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] s_quat_w,
    input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] s_quat_x,
    input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] s_quat_y,
    input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] s_quat_z,
    input  logic signed [qvr_pkg::VEC_WIDTH-1:0]  s_vec_x,
    input  logic signed [qvr_pkg::VEC_WIDTH-1:0]  s_vec_y,
    input  logic signed [qvr_pkg::VEC_WIDTH-1:0]  s_vec_z,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [qvr_pkg::VEC_WIDTH-1:0]  m_rot_x,
    output logic signed [qvr_pkg::VEC_WIDTH-1:0]  m_rot_y,
    output logic signed [qvr_pkg::VEC_WIDTH-1:0]  m_rot_z,
    output logic                                 m_sat_flag
);

    qvr_pkg::vec_t  vec_in;
    logic           prod_valid;
    logic           prod_ready;
    qvr_pkg::prod_t prod;
    qvr_pkg::vec_t  prod_vec;
    logic           dcm_valid;
    logic           dcm_ready;
    qvr_pkg::mat_t  mat;
    qvr_pkg::vec_t  dcm_vec;
    qvr_pkg::vec_t  rot;

    assign vec_in.x = s_vec_x;
    assign vec_in.y = s_vec_y;
    assign vec_in.z = s_vec_z;

    qvr_prod u_prod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_cmd    (s_cmd),
        .in_quat_w (s_quat_w),
        .in_quat_x (s_quat_x),
        .in_quat_y (s_quat_y),
        .in_quat_z (s_quat_z),
        .in_vec    (vec_in),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_prod  (prod),
        .out_vec   (prod_vec)
    );

    qvr_dcm u_dcm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_prod   (prod),
        .in_vec    (prod_vec),
        .out_valid (dcm_valid),
        .out_ready (dcm_ready),
        .out_mat   (mat),
        .out_vec   (dcm_vec)
    );

    qvr_mvm u_mvm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dcm_valid),
        .in_ready  (dcm_ready),
        .in_mat    (mat),
        .in_vec    (dcm_vec),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_rot   (rot),
        .out_sat   (m_sat_flag)
    );

    assign m_rot_x = rot.x;
    assign m_rot_y = rot.y;
    assign m_rot_z = rot.z;

endmodule

[tb/sv/tb_quaternion_vector_rotation_unit.sv]
// testbench: random and directed quaternion rotations checked against a behavioral predictor
`timescale 1ns / 100ps

module tb_quaternion_vector_rotation_unit;

    localparam int QW = qvr_pkg::QUAT_WIDTH;
    localparam int VW = qvr_pkg::VEC_WIDTH;
    localparam int NUM_RANDOM = 650;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT = 4000;

    localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW - 1){1'b1}}};
    localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW - 1){1'b0}}};
    localparam logic signed [VW-1:0] VMAX = qvr_pkg::VEC_MAX;
    localparam logic signed [VW-1:0] VMIN = qvr_pkg::VEC_MIN;

    typedef struct {
        logic                 cmd;
        logic signed [QW-1:0] qw;
        logic signed [QW-1:0] qx;
        logic signed [QW-1:0] qy;
        logic signed [QW-1:0] qz;
        logic signed [VW-1:0] vx;
        logic signed [VW-1:0] vy;
        logic signed [VW-1:0] vz;
    } attitude_t;

    typedef struct {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
        logic                 sat;
    } rotated_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_cmd = 1'b0;
    logic signed [QW-1:0] s_quat_w = '0;
    logic signed [QW-1:0] s_quat_x = '0;
    logic signed [QW-1:0] s_quat_y = '0;
    logic signed [QW-1:0] s_quat_z = '0;
    logic signed [VW-1:0] s_vec_x = '0;
    logic signed [VW-1:0] s_vec_y = '0;
    logic signed [VW-1:0] s_vec_z = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [VW-1:0] m_rot_x;
    logic signed [VW-1:0] m_rot_y;
    logic signed [VW-1:0] m_rot_z;
    logic                 m_sat_flag;

    attitude_t attitude_q[$];
    rotated_t  rotation_q[$];
    attitude_t cur_attitude;
    int        accepted_cnt = 0;
    int        mismatch_cnt = 0;
    int        quiet_cycles = 0;
    logic      steady;

    quaternion_vector_rotation_unit i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_quat_w   (s_quat_w),
        .s_quat_x   (s_quat_x),
        .s_quat_y   (s_quat_y),
        .s_quat_z   (s_quat_z),
        .s_vec_x    (s_vec_x),
        .s_vec_y    (s_vec_y),
        .s_vec_z    (s_vec_z),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_rot_x    (m_rot_x),
        .m_rot_y    (m_rot_y),
        .m_rot_z    (m_rot_z),
        .m_sat_flag (m_sat_flag)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // neither side inserts random idle cycles during this stretch
    assign steady = (accepted_cnt >= 300) && (accepted_cnt < 420);

    // matrix element with rounding to nearest, ties up
    function automatic longint to_mat_frac(input longint s);
        return (s + (longint'(1) <<< (qvr_pkg::FRAC_SHIFT - 1))) >>> qvr_pkg::FRAC_SHIFT;
    endfunction

    function automatic rotated_t rotate_vector(input attitude_t a);
        longint   w, x, y, z;
        longint   ww, wx, wy, wz, xx, xy, xz, yy, yz, zz;
        longint   m[9];
        longint   v[3];
        longint   acc, r;
        longint   res[3];
        rotated_t o;
        w = longint'(a.qw);
        x = longint'(a.qx);
        y = longint'(a.qy);
        z = longint'(a.qz);
        v[0] = longint'(a.vx);
        v[1] = longint'(a.vy);
        v[2] = longint'(a.vz);
        if (a.cmd) begin
            x = -x;
            y = -y;
            z = -z;
        end
        ww = w * w; wx = w * x; wy = w * y; wz = w * z;
        xx = x * x; xy = x * y; xz = x * z;
        yy = y * y; yz = y * z; zz = z * z;
        m[0] = to_mat_frac(ww + xx - yy - zz);
        m[1] = to_mat_frac(2 * (xy + wz));
        m[2] = to_mat_frac(2 * (xz - wy));
        m[3] = to_mat_frac(2 * (xy - wz));
        m[4] = to_mat_frac(ww - xx + yy - zz);
        m[5] = to_mat_frac(2 * (yz + wx));
        m[6] = to_mat_frac(2 * (wy + xz));
        m[7] = to_mat_frac(2 * (yz - wx));
        m[8] = to_mat_frac(ww - xx - yy + zz);
        o.sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            acc = m[3 * i] * v[0] + m[3 * i + 1] * v[1] + m[3 * i + 2] * v[2];
            r = (acc + (longint'(1) <<< (qvr_pkg::MAT_FRAC - 1))) >>> qvr_pkg::MAT_FRAC;
            if (r > longint'(VMAX)) begin
                r = longint'(VMAX);
                o.sat = 1'b1;
            end else if (r < longint'(VMIN)) begin
                r = longint'(VMIN);
                o.sat = 1'b1;
            end
            res[i] = r;
        end
        o.x = res[0][VW-1:0];
        o.y = res[1][VW-1:0];
        o.z = res[2][VW-1:0];
        return o;
    endfunction

    task automatic push_attitude(input logic c, input logic signed [QW-1:0] w, x, y, z,
                                 input logic signed [VW-1:0] vx, vy, vz);
        attitude_t a;
        a.cmd = c;
        a.qw = w; a.qx = x; a.qy = y; a.qz = z;
        a.vx = vx; a.vy = vy; a.vz = vz;
        attitude_q.push_back(a);
    endtask

    function automatic logic signed [QW-1:0] corner_quat();
        case ($urandom_range(5))
            0: return QMIN;
            1: return QMAX;
            2: return '0;
            3: return '1;
            4: return QW'(1);
            default: return QW'($urandom);
        endcase
    endfunction

    function automatic logic signed [VW-1:0] corner_vec();
        case ($urandom_range(5))
            0: return VMIN;
            1: return VMAX;
            2: return '0;
            3: return '1;
            4: return VW'(1);
            default: return VW'($urandom);
        endcase
    endfunction

    // roughly unit quaternion with random axis and sign
    task automatic make_unit_quat(output logic signed [QW-1:0] w, x, y, z);
        int  span;
        int  ix, iy, iz, iw;
        real one_sq;
        span = (1 << (QW - 1)) * 55 / 100;
        one_sq = real'(1 << (QW - 1)) * real'(1 << (QW - 1));
        ix = int'($urandom_range(2 * span)) - span;
        iy = int'($urandom_range(2 * span)) - span;
        iz = int'($urandom_range(2 * span)) - span;
        iw = $rtoi($sqrt(one_sq - real'(ix * ix + iy * iy + iz * iz)));
        if (iw > int'(QMAX))
            iw = int'(QMAX);
        if ($urandom_range(1))
            iw = -iw;
        w = QW'(iw); x = QW'(ix); y = QW'(iy); z = QW'(iz);
    endtask

    task automatic push_random_attitude();
        logic signed [QW-1:0] w, x, y, z;
        int                   kind;
        int                   lim;
        kind = $urandom_range(99);
        lim = $urandom_range(1, 1024);
        if (kind < 30) begin
            push_attitude(1'($urandom_range(1)), QW'($urandom), QW'($urandom), QW'($urandom),
                          QW'($urandom), VW'($urandom), VW'($urandom), VW'($urandom));
        end else if (kind < 65) begin
            make_unit_quat(w, x, y, z);
            push_attitude(1'($urandom_range(1)), w, x, y, z,
                          VW'($urandom), VW'($urandom), VW'($urandom));
        end else if (kind < 80) begin
            make_unit_quat(w, x, y, z);
            push_attitude(1'($urandom_range(1)), w, x, y, z,
                          VW'(int'($urandom_range(2 * lim)) - lim),
                          VW'(int'($urandom_range(2 * lim)) - lim),
                          VW'(int'($urandom_range(2 * lim)) - lim));
        end else begin
            push_attitude(1'($urandom_range(1)), corner_quat(), corner_quat(), corner_quat(),
                          corner_quat(), corner_vec(), corner_vec(), corner_vec());
        end
    endtask

    task automatic wait_drained();
        while (attitude_q.size() != 0 || s_valid || rotation_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic check_field(input string name, input logic signed [VW-1:0] exp_v,
                               input logic signed [VW-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
            mismatch_cnt++;
        end
    endtask

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                rotation_q.push_back(rotate_vector(cur_attitude));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!s_valid || s_ready) begin
                if (attitude_q.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
                    cur_attitude = attitude_q.pop_front();
                    s_valid  <= 1'b1;
                    s_cmd    <= cur_attitude.cmd;
                    s_quat_w <= cur_attitude.qw;
                    s_quat_x <= cur_attitude.qx;
                    s_quat_y <= cur_attitude.qy;
                    s_quat_z <= cur_attitude.qz;
                    s_vec_x  <= cur_attitude.vx;
                    s_vec_y  <= cur_attitude.vy;
                    s_vec_z  <= cur_attitude.vz;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 30);
        end
    end

    always @(posedge aclk) begin
        rotated_t exp_rot;
        if (aresetn && m_valid && m_ready) begin
            if (rotation_q.size() == 0) begin
                $display("%0t unexpected word: actual %0d %0d %0d sat %0b", $time,
                         m_rot_x, m_rot_y, m_rot_z, m_sat_flag);
                mismatch_cnt++;
            end else begin
                exp_rot = rotation_q.pop_front();
                check_field("rot_x", exp_rot.x, m_rot_x);
                check_field("rot_y", exp_rot.y, m_rot_y);
                check_field("rot_z", exp_rot.z, m_rot_z);
                check_field("sat_flag", VW'(exp_rot.sat), VW'(m_sat_flag));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t timeout: %0d words still expected", $time, rotation_q.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        push_attitude(1'b0, '0, '0, '0, '0, VMAX, VMAX, VMAX);
        push_attitude(1'b0, QMAX, '0, '0, '0, VMAX, VMIN, '0);
        push_attitude(1'b1, QMAX, '0, '0, '0, VMIN, VMAX, '1);
        push_attitude(1'b1, QMIN, QMIN, QMIN, QMIN, VW'(1000), -VW'(2000), VW'(3000));
        push_attitude(1'b0, QMIN, QMIN, QMIN, QMIN, VMAX, VMAX, VMAX);
        push_attitude(1'b0, QMIN, '0, '0, '0, VMIN, VMIN, VMIN);
        push_attitude(1'b1, '0, QMIN, '0, '0, VMAX, VMIN, VMAX);
        push_attitude(1'b0, '0, '0, QMAX, '0, VMIN, VMAX, VMIN);
        push_attitude(1'b0, '0, '0, '0, QMIN, VMAX, VMAX, VMIN);
        push_attitude(1'b1, '0, '0, '0, QMIN, VMIN, VMIN, VMAX);
        push_attitude(1'b0, QMAX, QMAX, QMAX, QMAX, VMAX, VMIN, VMAX);
        push_attitude(1'b0, QW'(23170), '0, '0, QW'(23170), VW'(100), '0, '0);
        push_attitude(1'b1, QW'(23170), '0, '0, QW'(23170), VW'(100), '0, '0);
        push_attitude(1'b1, QMAX, QMIN, QMAX, QMIN, VMIN, VMIN, VMAX);
        push_attitude(1'b0, '1, QW'(1), '1, QW'(1), VMAX, VMAX, VMAX);
        push_attitude(1'b1, QW'(16384), QW'(16384), QW'(16384), QW'(16384),
                      VW'(1), '1, VW'(3));
        push_attitude(1'b0, QMAX, '0, '0, '0, '0, '0, '0);
        wait_drained();

        repeat (NUM_RANDOM / 2)
            push_random_attitude();
        wait_drained();

        repeat (NUM_RANDOM - NUM_RANDOM / 2)
            push_random_attitude();
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (rotation_q.size() != 0) begin
            $display("%0t %0d expected words never arrived", $time, rotation_q.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/qvr_pkg.sv
rtl/core/qvr_prod.sv
rtl/core/qvr_dcm.sv
rtl/core/qvr_mvm.sv
rtl/core/quaternion_vector_rotation_unit.sv
tb/sv/tb_quaternion_vector_rotation_unit.sv
